### rtl/core/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants of the gradient colormap
// Holds the stop table, field widths and pipeline control types.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int IN_W              = 18;
  localparam int CH_W              = 8;
  localparam int STOP_COUNT        = 11;
  localparam int IDX_W             = $clog2(STOP_COUNT);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  // Load enables of the two blend stages
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } stage_en_t;

  localparam color_t STOP_TABLE [STOP_COUNT] = '{
    '{red: 8'd254, green: 8'd39,  blue: 8'd18},
    '{red: 8'd253, green: 8'd83,  blue: 8'd8},
    '{red: 8'd251, green: 8'd153, blue: 8'd2},
    '{red: 8'd250, green: 8'd188, blue: 8'd2},
    '{red: 8'd254, green: 8'd254, blue: 8'd51},
    '{red: 8'd208, green: 8'd234, blue: 8'd43},
    '{red: 8'd102, green: 8'd176, blue: 8'd50},
    '{red: 8'd3,   green: 8'd146, blue: 8'd206},
    '{red: 8'd2,   green: 8'd71,  blue: 8'd254},
    '{red: 8'd61,  green: 8'd1,   blue: 8'd164},
    '{red: 8'd134, green: 8'd1,   blue: 8'd175}
  };

endpackage

### rtl/core/gcl_if.sv
// ----------------------------------------------------------------------------
// gcl_scalar_if / gcl_color_if: stream channels of the gradient colormap
// Valid/ready channels for the scalar input and the color result.
// ----------------------------------------------------------------------------
interface gcl_scalar_if
  import gcl_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] scalar_in;

  modport source (output valid, output scalar_in, input ready);
  modport sink   (input valid, input scalar_in, output ready);
endinterface

interface gcl_color_if
  import gcl_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

### rtl/core/gcl_blend.sv
// ----------------------------------------------------------------------------
// gcl_blend: one color channel blend
// Weights two neighboring stops by the fraction, then rounds to 8 bits.
// ----------------------------------------------------------------------------
module gcl_blend
  import gcl_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic [CH_W-1:0]        lo_i,
  input  logic [CH_W-1:0]        hi_i,
  input  logic [FRACTION_BITS:0] frac_i,
  input  stage_en_t              en_i,
  output logic [CH_W-1:0]        chan_o
);

  localparam int FW = FRACTION_BITS + 1;
  localparam int PW = FW + CH_W;
  localparam logic [FW-1:0] ONE_C  = FW'(1) << FRACTION_BITS;
  localparam logic [PW:0]   HALF_C = (PW + 1)'(1) << (FRACTION_BITS - 1);

  logic [PW-1:0] prod_hi_q, prod_lo_q;
  logic [PW:0]   acc;
  logic [CH_W-1:0] chan_q;

  // Weighted stops, registered before the sum
  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      prod_hi_q <= PW'(frac_i) * PW'(hi_i);
      prod_lo_q <= PW'(ONE_C - frac_i) * PW'(lo_i);
    end
  end

  assign acc = (PW + 1)'(prod_hi_q) + (PW + 1)'(prod_lo_q) + HALF_C;

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      chan_q <= acc[FRACTION_BITS +: CH_W];
    end
  end

  assign chan_o = chan_q;

endmodule

### rtl/core/gradient_colormap_lerp.sv
// ----------------------------------------------------------------------------
// gradient_colormap_lerp: false-color map with linear interpolation
// Turns a fixed-point scalar into an RGB color from an 11-stop gradient.
// ----------------------------------------------------------------------------
// The block takes one signed scalar with FRACTION_BITS fraction bits per
// transfer, clamps it to 0..1.0, scales it by ten and blends the two
// neighboring stops of a fixed 11-stop table per channel, rounded to nearest.
// It accepts one transfer every cycle while the output side does not stall.
// The four register stages are clamp, scale/split, per-channel multiply,
// and sum/round; each stage holds while the one after it is full and
// stalled, so a stall on the output fills bubbles first before the input
// side sees ready drop.
// ----------------------------------------------------------------------------
module gradient_colormap_lerp
  import gcl_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcl_scalar_if.sink   scalar_i,
  gcl_color_if.source  color_o
);

  localparam int FW = FRACTION_BITS + 1;            // fraction incl. full weight
  localparam int SW = FRACTION_BITS + IDX_W;        // ten times the clamped value
  localparam int CW = (FRACTION_BITS + 2 > IN_W) ? FRACTION_BITS + 2 : IN_W;
  localparam logic [CW-1:0]    ONE_CMP = CW'(1) << FRACTION_BITS;
  localparam logic [FW-1:0]    ONE_C   = FW'(1) << FRACTION_BITS;
  localparam logic [IDX_W-1:0] TOP_SEG = IDX_W'(STOP_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_LO = IDX_W'(STOP_COUNT - 2);

  // Stage valid bits and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = ~v4_q | color_o.ready;
  assign adv3 = ~v3_q | adv4;
  assign adv2 = ~v2_q | adv3;
  assign adv1 = ~v1_q | adv2;

  assign scalar_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= scalar_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Stage 1: clamp to 0..1.0. Negative inputs go to zero; the upper clamp
  // only bites when 1.0 is within the input range.
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] clamp_d;
  logic [FW-1:0] val_q;

  assign pos_ext = CW'(scalar_i.scalar_in[IN_W-2:0]);

  always_comb begin
    if (scalar_i.scalar_in[IN_W-1]) begin
      clamp_d = '0;
    end else if (pos_ext > ONE_CMP) begin
      clamp_d = ONE_CMP;
    end else begin
      clamp_d = pos_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      val_q <= clamp_d[FW-1:0];
    end
  end

  // Stage 2: scale by ten (8x + 2x), split into stop index and fraction.
  // At exactly 1.0, fold onto the last segment at full weight.
  logic [SW-1:0]    scaled;
  logic [IDX_W-1:0] idx_raw, idx_d, idx_q;
  logic [FW-1:0]    frac_d, frac_q;

  assign scaled  = (SW'(val_q) << 3) + (SW'(val_q) << 1);
  assign idx_raw = scaled[FRACTION_BITS +: IDX_W];

  always_comb begin
    if (idx_raw >= TOP_SEG) begin
      idx_d  = LAST_LO;
      frac_d = ONE_C;
    end else begin
      idx_d  = idx_raw;
      frac_d = FW'(scaled[FRACTION_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      idx_q  <= idx_d;
      frac_q <= frac_d;
    end
  end

  // Stages 3 and 4: per-channel blend of the neighboring stops
  color_t    lo_c, hi_c;
  stage_en_t blend_en;
  logic [IDX_W-1:0] idx_hi;

  assign idx_hi = idx_q + IDX_W'(1);
  assign lo_c   = STOP_TABLE[idx_q];
  assign hi_c   = STOP_TABLE[idx_hi];

  assign blend_en.prod_en = adv3;
  assign blend_en.sum_en  = adv4;

  gcl_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_red (
    .clk_i  (clk_i),
    .lo_i   (lo_c.red),
    .hi_i   (hi_c.red),
    .frac_i (frac_q),
    .en_i   (blend_en),
    .chan_o (color_o.red_out)
  );

  gcl_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_green (
    .clk_i  (clk_i),
    .lo_i   (lo_c.green),
    .hi_i   (hi_c.green),
    .frac_i (frac_q),
    .en_i   (blend_en),
    .chan_o (color_o.green_out)
  );

  gcl_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_blue (
    .clk_i  (clk_i),
    .lo_i   (lo_c.blue),
    .hi_i   (hi_c.blue),
    .frac_i (frac_q),
    .en_i   (blend_en),
    .chan_o (color_o.blue_out)
  );

  assign color_o.valid = v4_q;

endmodule

### rtl/core/gcl_checker.sv
// ----------------------------------------------------------------------------
// gcl_checker: port-level checks of the gradient colormap
// Tracks items in flight and checks flow, latency and output hold.
// ----------------------------------------------------------------------------
module gcl_checker
  import gcl_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [CH_W-1:0] red_i,
  input logic [CH_W-1:0] green_i,
  input logic [CH_W-1:0] blue_i
);

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_q;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // Never more items inside than pipeline stages, never a result from nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q <= 3'd4) && (!out_valid_i || inflight_q != 3'd0))
    else $error("gcl: item count out of range");

  // A ready output side lets the input side flow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("gcl: input stalled while output ready");

  // An input transfer reaches the output through a free-flowing pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_xfer, 4) && $past(out_ready_i, 3) && $past(out_ready_i, 2) &&
     $past(out_ready_i, 1)) |-> out_valid_i)
    else $error("gcl: result missing after pipeline latency");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i)))
    else $error("gcl: stalled result changed");

endmodule

bind gradient_colormap_lerp gcl_checker u_gcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (scalar_i.valid),
  .in_ready_i  (scalar_i.ready),
  .out_valid_i (color_o.valid),
  .out_ready_i (color_o.ready),
  .red_i       (color_o.red_out),
  .green_i     (color_o.green_out),
  .blue_i      (color_o.blue_out)
);
